// ----- rtl/core/cfir_pkg.sv -----
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared constants and types of the complex I/Q FIR filter: field widths,
// item codes and the records handed along the tap chain.
// ----------------------------------------------------------------------------
package cfir_pkg;

  localparam int TAPS        = 64;
  localparam int SAMPLE_W    = 16;
  localparam int SMP_FIELD_W = 16;
  localparam int COEF_W      = 16;
  localparam int COEF_FRAC   = 15;
  localparam int IDX_W       = 6;
  localparam int OUT_W       = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = PROD_W + $clog2(TAPS);

  // item codes
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
  } iq_smp_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] i;
    logic signed [COEF_W-1:0] q;
  } coef_t;

  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] i;
    logic signed [ACC_W-1:0] q;
  } psum_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ----- rtl/core/cfir_if.sv -----
// ----------------------------------------------------------------------------
// cfir_in_if / cfir_out_if
// Valid/ready channels of the complex I/Q FIR filter.
// ----------------------------------------------------------------------------
interface cfir_in_if import cfir_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SMP_FIELD_W-1:0] sample_i;
  logic signed [SMP_FIELD_W-1:0] sample_q;
  logic        [IDX_W-1:0]       coef_index;
  logic signed [COEF_W-1:0]      coef_i;
  logic signed [COEF_W-1:0]      coef_q;

  modport source (
    output valid, cmd, sample_i, sample_q, coef_index, coef_i, coef_q,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample_i, sample_q, coef_index, coef_i, coef_q,
    output ready
  );
endinterface

interface cfir_out_if import cfir_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_i;
  logic signed [OUT_W-1:0] out_q;
  logic                    saturated;

  modport source (
    output valid, out_i, out_q, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_i, out_q, saturated,
    output ready
  );
endinterface

// ----- rtl/core/cfir_cell.sv -----
// ----------------------------------------------------------------------------
// cfir_cell
// One tap of the chain: holds a sample pair and a coefficient pair, and adds
// its two products to the partial sums passing through from its neighbor.
// ----------------------------------------------------------------------------
module cfir_cell import cfir_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  iq_smp_t   smp_in,
  input  coef_t     coef_in,
  output iq_smp_t   smp_out,
  input  psum_t     psum_in,
  output psum_t     psum_out
);

  iq_smp_t smp_r, smp_nxt;
  coef_t   coef_r, coef_nxt;
  psum_t   psum_r, psum_nxt;

  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_q;

  assign prod_i = $signed(smp_r.i) * $signed(coef_r.i);
  assign prod_q = $signed(smp_r.q) * $signed(coef_r.q);

  always_comb begin
    smp_nxt  = ctl.shift ? smp_in : smp_r;
    coef_nxt = ctl.load ? coef_in : coef_r;
    psum_nxt = psum_r;
    psum_nxt.vld = psum_in.vld;
    // sums only move with the token so the chain end holds its value
    if (psum_in.vld) begin
      psum_nxt.i = psum_in.i + ACC_W'(prod_i);
      psum_nxt.q = psum_in.q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r  <= '0;
      coef_r <= '0;
      psum_r <= '0;
    end else begin
      smp_r  <= smp_nxt;
      coef_r <= coef_nxt;
      psum_r <= psum_nxt;
    end
  end

  assign smp_out  = smp_r;
  assign psum_out = psum_r;

endmodule

// ----- rtl/core/cfir_rndsat.sv -----
// ----------------------------------------------------------------------------
// cfir_rndsat
// Rounds a full-precision tap sum to the sample format (round half up) and
// clips it to the signed sample range.
// ----------------------------------------------------------------------------
module cfir_rndsat import cfir_pkg::*; (
  input  logic signed [ACC_W-1:0] acc,
  output logic signed [OUT_W-1:0] y,
  output logic                    clip
);

  logic [ACC_W:0]                 half_c;
  logic [ACC_W:0]                 rnd;
  logic [ACC_W-COEF_FRAC:0]       shr;
  logic [ACC_W-COEF_FRAC-SAMPLE_W+1:0] hi_bits;
  logic [SAMPLE_W-1:0]            clipped;

  assign half_c  = {{(ACC_W-COEF_FRAC+1){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  assign rnd     = {acc[ACC_W-1], acc} + half_c;
  // dropping the low bits of a two's complement value is a floor
  assign shr     = rnd[ACC_W:COEF_FRAC];
  assign hi_bits = shr[ACC_W-COEF_FRAC:SAMPLE_W-1];
  assign clip    = !((&hi_bits) || !(|hi_bits));

  always_comb begin
    if (clip) begin
      clipped = {shr[ACC_W-COEF_FRAC], {(SAMPLE_W-1){~shr[ACC_W-COEF_FRAC]}}};
    end else begin
      clipped = shr[SAMPLE_W-1:0];
    end
  end

  assign y = OUT_W'($signed(clipped));

endmodule

// ----- rtl/core/complex_iq_fir_filter.sv -----
// ----------------------------------------------------------------------------
// complex_iq_fir_filter
// Two real FIR filters (I and Q rails) built as a chain of tap cells. A load
// item writes one coefficient pair; a filter item shifts in a sample pair and
// sends a partial-sum token down the chain, one cell per cycle.
//
//   channel  dir  transfer when            payload
//   in_ch    in   in_ch.valid & ready      cmd, sample_i/q, coef_index, coef_i/q
//   out_ch   out  out_ch.valid & ready     out_i, out_q, saturated
//
// A load item completes at its transfer. After a filter item's transfer, the
// input stays blocked while the start register launches the token, the token
// walks the TAPS cells, and the result is rounded and taken into the output register.
// The result waits in an output register, so the next item is taken while it
// is still pending; a chain result that finds the register full is held at
// the chain end until the register drains.
// Synchronous active-low reset clears all samples and coefficients to zero.
// ----------------------------------------------------------------------------
module complex_iq_fir_filter import cfir_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cfir_in_if.sink           in_ch,
  cfir_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   start_r, start_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic signed [OUT_W-1:0] out_i_r, out_i_nxt;
  logic signed [OUT_W-1:0] out_q_r, out_q_nxt;
  logic   sat_r, sat_nxt;

  logic    in_fire, filt_fire, load_fire;
  logic    done, out_free, take;
  iq_smp_t new_smp;
  coef_t   new_coef;
  iq_smp_t smp  [TAPS];
  psum_t   link [TAPS+1];
  logic [TAPS:0] tok_vec;

  logic signed [OUT_W-1:0] y_i, y_q;
  logic                    clip_i, clip_q;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign filt_fire   = in_fire && (in_ch.cmd == CMD_FILTER);
  assign load_fire   = in_fire && (in_ch.cmd == CMD_LOAD);

  assign new_smp.i  = in_ch.sample_i[SAMPLE_W-1:0];
  assign new_smp.q  = in_ch.sample_q[SAMPLE_W-1:0];
  assign new_coef.i = in_ch.coef_i;
  assign new_coef.q = in_ch.coef_q;

  assign link[0].vld = start_r;
  assign link[0].i   = '0;
  assign link[0].q   = '0;
  assign tok_vec[0]  = start_r;

  // cell 0 takes the new sample, the last cell the old newest, cell k the
  // sample of cell k+1, so cell k (k > 0) holds the sample from TAPS - k items back
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    cell_ctl_t ctl;
    iq_smp_t   nb_smp;

    assign ctl.shift = filt_fire;
    assign ctl.load  = load_fire && (32'(in_ch.coef_index) == 32'(k));

    if (k == 0) begin : g_head
      assign nb_smp = new_smp;
    end else begin : g_body
      assign nb_smp = smp[(k + 1) % TAPS];
    end

    cfir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .smp_in   (nb_smp),
      .coef_in  (new_coef),
      .smp_out  (smp[k]),
      .psum_in  (link[k]),
      .psum_out (link[k+1])
    );

    assign tok_vec[k+1] = link[k+1].vld;
  end

  cfir_rndsat u_rnd_i (
    .acc  (link[TAPS].i),
    .y    (y_i),
    .clip (clip_i)
  );

  cfir_rndsat u_rnd_q (
    .acc  (link[TAPS].q),
    .y    (y_q),
    .clip (clip_q)
  );

  assign done     = link[TAPS].vld;
  assign out_free = !out_vld_r || out_ch.ready;
  assign take     = ((state_r == ST_RUN && done) || state_r == ST_HOLD) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (filt_fire) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (done) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    start_nxt   = filt_fire;
    out_vld_nxt = take ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
    out_i_nxt   = take ? y_i : out_i_r;
    out_q_nxt   = take ? y_q : out_q_r;
    sat_nxt     = take ? (clip_i || clip_q) : sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_i_r <= out_i_nxt;
    out_q_r <= out_q_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_i     = out_i_r;
  assign out_ch.out_q     = out_q_r;
  assign out_ch.saturated = sat_r;

  // only one partial-sum token in the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one token in the tap chain");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == ST_RUN)
    else $error("chain result outside of a running item");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> out_vld_r)
    else $error("holding a result while the output register is empty");

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_vld_r)
    else $error("taken result not presented");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    filt_fire |=> start_r && state_r == ST_RUN)
    else $error("filter transfer did not launch a token");

endmodule
